// ----- hw/rtl/gsoc_pkg.sv -----
// Shared constants and types for the gyro still-offset calibrator.
// No dependencies; used by gsoc_lane, gsoc_merge and the top level.
package gsoc_pkg;

    localparam int SAMPLE_W   = 16;                  // raw sample width
    localparam int FRAC_W     = 16;                  // fraction bits of mean/bias
    localparam int MEAN_W     = SAMPLE_W + FRAC_W;   // Q16.16 mean, bias, change mean
    localparam int DIFF_W     = MEAN_W + 1;          // difference of two Q16.16 values
    localparam int WEIGHT_W   = 16;                  // Q0.16 weight and gain
    localparam int PROD_W     = DIFF_W + WEIGHT_W + 1;
    localparam int RATE_W     = 25;
    localparam int RATE_SHIFT = FRAC_W + 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int IN_W       = 2 * SAMPLE_W;
    localparam int OUT_W      = 56;                  // 54 used bits padded to bytes
    localparam int LANES      = 2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 16'd655;
    localparam logic [MEAN_W-1:0]   THRESHOLD_RESET = 32'd262144;
    localparam logic [MEAN_W-1:0]   RELOAD_RESET    = 32'd6553600;
    localparam logic [WEIGHT_W-1:0] GAIN_RESET      = 16'd655;
    localparam logic [1:0]          CAL_DONE        = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT    = 4'd0,
        CFG_THRESHOLD = 4'd1,
        CFG_RELOAD    = 4'd2,
        CFG_GAIN      = 4'd3
    } t_cfg_index;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [MEAN_W-1:0]   threshold;
        logic [MEAN_W-1:0]   reload;
        logic [WEIGHT_W-1:0] gain;
    } t_cfg;

    typedef struct packed {
        logic load;     // item accepted: run the EMA multiplies
        logic update;   // commit state and hand the difference on
    } t_lane_ctl;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;  // sample*2^F minus updated bias
        logic                     recal;
        logic                     calibrated;
    } t_lane_out;

endpackage

// ----- hw/rtl/gyro_still_offset_calibrator_unit.sv -----
// Gyro still-offset calibrator, two axis lanes (x, y) and a merge stage.
// Path to m_axis_tvalid: lane product, lane result and merge output registers.
// A new item is taken only after the last has committed; the EMA multiply feeds
// the stillness compare and state update, which the next item's multiply reads back.
// Reset (i_rst_n low, synchronous): clears the pipeline, loads register defaults,
// change means to the default reload value, means, biases and counts to zero.
module gyro_still_offset_calibrator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input item: [15:0] sample_x, [31:16] sample_y
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [gsoc_pkg::IN_W-1:0]         s_axis_tdata,
    // result item: [24:0] rate_x, [49:25] rate_y, [50] calibrated_x,
    // [51] calibrated_y, [52] recal_x, [53] recal_y, [55:54] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [gsoc_pkg::OUT_W-1:0]        m_axis_tdata,
    // register write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gsoc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gsoc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SW = gsoc_pkg::SAMPLE_W;

    gsoc_pkg::t_cfg      r_cfg;
    gsoc_pkg::t_lane_ctl lane_ctl;
    gsoc_pkg::t_lane_out lane_out [gsoc_pkg::LANES];

    logic r_v1;   // lane products hold an item
    logic r_v2;   // lane results hold an item for the merge
    logic accept;
    logic adv1;
    logic adv2;
    logic merge_ready;

    // Registers take writes at any time; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight    <= gsoc_pkg::WEIGHT_RESET;
            r_cfg.threshold <= gsoc_pkg::THRESHOLD_RESET;
            r_cfg.reload    <= gsoc_pkg::RELOAD_RESET;
            r_cfg.gain      <= gsoc_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (gsoc_pkg::t_cfg_index'(i_cfg_index))
                gsoc_pkg::CFG_WEIGHT:    r_cfg.weight    <= i_cfg_data[gsoc_pkg::WEIGHT_W-1:0];
                gsoc_pkg::CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data;
                gsoc_pkg::CFG_RELOAD:    r_cfg.reload    <= i_cfg_data;
                gsoc_pkg::CFG_GAIN:      r_cfg.gain      <= i_cfg_data[gsoc_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Take a new item only once the previous one has committed its state,
    // so the lane multiplies always see the updated averages.
    assign s_axis_tready = !r_v1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    // Advance the lane results into the merge when the output register frees up.
    assign adv2          = r_v2 && merge_ready;
    // Commit lane state when the result slot ahead is empty or moving.
    assign adv1          = r_v1 && (!r_v2 || adv2);

    assign lane_ctl.load   = accept;
    assign lane_ctl.update = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end
        end
    end

    gsoc_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_cfg    (r_cfg),
        .i_sample (s_axis_tdata[SW-1:0]),
        .o_result (lane_out[0])
    );

    gsoc_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_cfg    (r_cfg),
        .i_sample (s_axis_tdata[2*SW-1:SW]),
        .o_result (lane_out[1])
    );

    gsoc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .o_ready (merge_ready),
        .i_gain  (r_cfg.gain),
        .i_lane  (lane_out),
        .o_valid (m_axis_tvalid),
        .i_take  (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // An accepted item occupies the product stage and blocks the next accept.
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1 && !s_axis_tready)
        else $error("accepted item did not occupy the product stage");

    // A committed lane result always lands in the result slot.
    a_commit_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv1 |=> r_v2)
        else $error("committed lane result lost");

    // A stalled product stage keeps its item.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !adv1 |=> r_v1)
        else $error("product stage dropped a stalled item");

    // A result moving into the merge shows up at the output.
    a_merge_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv2 |=> m_axis_tvalid)
        else $error("merged item missing at the output");
`endif

endmodule

// ----- hw/rtl/gsoc_lane.sv -----
// One axis of the calibrator: sample and change EMAs, stillness test, bias update.
// Depends on gsoc_pkg.
module gsoc_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gsoc_pkg::t_lane_ctl                 i_ctl,
    input  gsoc_pkg::t_cfg                      i_cfg,
    input  logic signed [gsoc_pkg::SAMPLE_W-1:0] i_sample,
    output gsoc_pkg::t_lane_out                 o_result
);

    localparam int MW = gsoc_pkg::MEAN_W;
    localparam int DW = gsoc_pkg::DIFF_W;
    localparam int PW = gsoc_pkg::PROD_W;
    localparam int FW = gsoc_pkg::FRAC_W;
    localparam int SW = gsoc_pkg::SAMPLE_W;

    // architectural state
    logic signed [SW-1:0] r_previous;
    logic signed [MW-1:0] r_mean, n_mean;
    logic        [MW-1:0] r_change_mean, n_change_mean;
    logic signed [MW-1:0] r_bias, n_bias;
    logic        [1:0]    r_count, n_count;

    // first stage: scaled products and differences
    logic signed [DW-1:0] r_dm, r_dbo, r_pm, r_pc;
    // second stage: result toward the merge
    gsoc_pkg::t_lane_out  r_out, n_out;

    logic signed [MW-1:0] scaled;
    logic signed [SW:0]   delta;
    logic        [SW-1:0] delta_abs;
    logic        [MW-1:0] change;
    logic signed [DW-1:0] dm, dc, dbo;
    logic signed [PW-1:0] prod_m, prod_c;
    logic signed [DW:0]   cm_sum;
    logic signed [DW-1:0] mean_sum, dmn;
    logic                 recal;

    always_comb begin
        scaled    = {i_sample, {FW{1'b0}}};
        delta     = {i_sample[SW-1], i_sample} - {r_previous[SW-1], r_previous};
        delta_abs = delta[SW] ? SW'(-delta) : delta[SW-1:0];
        change    = {delta_abs, {FW{1'b0}}};
        dm        = {scaled[MW-1], scaled} - {r_mean[MW-1], r_mean};
        dbo       = {scaled[MW-1], scaled} - {r_bias[MW-1], r_bias};
        dc        = $signed({1'b0, change}) - $signed({1'b0, r_change_mean});
        prod_m    = dm * $signed({1'b0, i_cfg.weight});
        prod_c    = dc * $signed({1'b0, i_cfg.weight});
    end

    // floor((new - old) * w / 2^16) added to old equals the weighted average
    always_comb begin
        mean_sum      = {r_mean[MW-1], r_mean} + r_pm;
        cm_sum        = $signed({2'b00, r_change_mean}) + {r_pc[DW-1], r_pc};
        dmn           = r_dm - r_pm;
        n_mean        = mean_sum[MW-1:0];
        n_change_mean = cm_sum[MW-1:0];
        recal         = cm_sum[MW-1:0] < i_cfg.threshold;
        n_bias        = r_bias;
        n_count       = r_count;
        if (recal) begin
            n_bias        = mean_sum[MW-1:0];
            n_change_mean = i_cfg.reload;
            if (r_count != gsoc_pkg::CAL_DONE) begin
                n_count = r_count + 2'd1;
            end
        end
        n_out.diff       = recal ? dmn : r_dbo;
        n_out.recal      = recal;
        n_out.calibrated = (n_count == gsoc_pkg::CAL_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous    <= '0;
            r_mean        <= '0;
            r_change_mean <= gsoc_pkg::RELOAD_RESET;
            r_bias        <= '0;
            r_count       <= '0;
        end else begin
            if (i_ctl.load) begin
                r_previous <= i_sample;
            end
            if (i_ctl.update) begin
                r_mean        <= n_mean;
                r_change_mean <= n_change_mean;
                r_bias        <= n_bias;
                r_count       <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dm  <= dm;
            r_dbo <= dbo;
            r_pm  <= prod_m[DW+FW-1:FW];
            r_pc  <= prod_c[DW+FW-1:FW];
        end
        if (i_ctl.update) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

// ----- hw/rtl/gsoc_merge.sv -----
// Merge stage: scale both lane differences by the frame gain, saturate, pack the item.
// Depends on gsoc_pkg; holds the output register of the master side.
module gsoc_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [gsoc_pkg::WEIGHT_W-1:0]   i_gain,
    input  gsoc_pkg::t_lane_out             i_lane [gsoc_pkg::LANES],
    output logic                            o_valid,
    input  logic                            i_take,
    output logic [gsoc_pkg::OUT_W-1:0]      o_data
);

    localparam int PW = gsoc_pkg::PROD_W;
    localparam int RW = gsoc_pkg::RATE_W;
    localparam int SH = gsoc_pkg::RATE_SHIFT;
    localparam int TW = PW - SH;

    logic signed [PW-1:0] prod [gsoc_pkg::LANES];
    logic signed [TW-1:0] shifted [gsoc_pkg::LANES];
    logic signed [RW-1:0] rate [gsoc_pkg::LANES];
    logic                 r_valid;
    logic [gsoc_pkg::OUT_W-1:0] r_data, n_data;

    always_comb begin
        for (int l = 0; l < gsoc_pkg::LANES; l++) begin
            prod[l]    = i_lane[l].diff * $signed({1'b0, i_gain});
            shifted[l] = prod[l][PW-1:SH];
            if (shifted[l][TW-1] != shifted[l][RW-1]) begin
                rate[l] = shifted[l][TW-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
            end else begin
                rate[l] = shifted[l][RW-1:0];
            end
        end
        n_data = {2'b00,
                  i_lane[1].recal, i_lane[0].recal,
                  i_lane[1].calibrated, i_lane[0].calibrated,
                  rate[1], rate[0]};
    end

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
